### hdl/bsdp_pkg.sv
// Shared types and constants for the button/switch debounce packetizer.
// No dependencies; used by every module in hdl/.
`timescale 1ns / 1ps
`default_nettype none

package bsdp_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int SENS_W   = 3;
    localparam int IDX_W    = 3;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    // Default depth of the front-to-back command queue
    localparam int QUEUE_DEPTH_DEF = 4;

    // Configuration register indexes
    localparam logic CFG_SYNC = 1'b0;
    localparam logic CFG_ADDR = 1'b1;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hFF;
    localparam logic [BYTE_W-1:0] ADDR_RESET = 8'hAA;

    // Idle port value (active low, nothing pressed)
    localparam logic [BYTE_W-1:0] PORT_IDLE = 8'hFF;

    // Click codes
    localparam logic [BYTE_W-1:0] PRESS_B7   = 8'h80;
    localparam logic [BYTE_W-1:0] PRESS_B6   = 8'h40;
    localparam logic [BYTE_W-1:0] PRESS_B5   = 8'h20;
    localparam logic [BYTE_W-1:0] RELEASE_B7 = 8'h01;
    localparam logic [BYTE_W-1:0] RELEASE_B6 = 8'h02;
    localparam logic [BYTE_W-1:0] RELEASE_B5 = 8'h04;

    // Sensitivity levels from switch bit 0
    localparam logic [SENS_W-1:0] SENS_LOW  = 3'd3;
    localparam logic [SENS_W-1:0] SENS_HIGH = 3'd4;

    // Byte positions inside a packet
    localparam logic [IDX_W-1:0] IDX_SYNC = 3'd0;
    localparam logic [IDX_W-1:0] IDX_ADDR = 3'd1;
    localparam logic [IDX_W-1:0] IDX_CODE = 3'd5;

    // Four-state debounce phase
    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_MAYBE_ON  = 4'b0010,
        PH_ON        = 4'b0100,
        PH_MAYBE_OFF = 4'b1000
    } t_phase;

    // One classified item handed from front to back
    typedef struct packed {
        logic              send;
        logic [BYTE_W-1:0] code;
        logic              move;
        logic              scroll;
        logic              calib;
        logic [SENS_W-1:0] sens;
        logic              inv_x;
        logic              inv_y;
    } t_cmd;

endpackage

`default_nettype wire

### hdl/bsdp_front.sv
// Front end: button and switch debounce machines, classifies each sample
// into a command. Depends on bsdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsdp_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic [bsdp_pkg::BYTE_W-1:0] i_buttons,
    input  wire logic [bsdp_pkg::BYTE_W-1:0] i_switches,
    output bsdp_pkg::t_cmd                   o_cmd
);

    bsdp_pkg::t_phase                  r_btn_ph, n_btn_ph;
    bsdp_pkg::t_phase                  r_sw_ph, n_sw_ph;
    logic [bsdp_pkg::BYTE_W-1:0]       r_btn_snap, n_btn_snap;
    logic [bsdp_pkg::BYTE_W-1:0]       r_sw_snap, n_sw_snap;
    logic                              r_move, n_move;
    logic                              r_scroll, n_scroll;
    logic [bsdp_pkg::SENS_W-1:0]       r_sens, n_sens;
    logic                              r_inv_x, n_inv_x;
    logic                              r_inv_y, n_inv_y;
    logic                              send;
    logic                              calib;
    logic                              apply_sw;
    logic [bsdp_pkg::BYTE_W-1:0]       code;

    // Button debounce and click classification
    always_comb begin
        n_btn_ph   = r_btn_ph;
        n_btn_snap = r_btn_snap;
        n_move     = r_move;
        n_scroll   = r_scroll;
        send       = 1'b0;
        calib      = 1'b0;
        code       = '0;
        unique case (r_btn_ph)
            bsdp_pkg::PH_IDLE: begin
                if (i_buttons != bsdp_pkg::PORT_IDLE) begin
                    n_btn_ph   = bsdp_pkg::PH_MAYBE_ON;
                    n_btn_snap = i_buttons;
                end
            end
            bsdp_pkg::PH_MAYBE_ON: begin
                if (r_btn_snap == i_buttons) begin
                    n_btn_ph = bsdp_pkg::PH_ON;
                    priority if (!i_buttons[7]) begin
                        send = 1'b1;
                        code = bsdp_pkg::PRESS_B7;
                    end else if (!i_buttons[6]) begin
                        send = 1'b1;
                        code = bsdp_pkg::PRESS_B6;
                    end else if (!i_buttons[5]) begin
                        send = 1'b1;
                        code = bsdp_pkg::PRESS_B5;
                    end else begin
                        // only bits without a click code held
                        send = 1'b0;
                    end
                end else begin
                    n_btn_ph = bsdp_pkg::PH_IDLE;
                end
            end
            bsdp_pkg::PH_ON: begin
                if (r_btn_snap != i_buttons) n_btn_ph = bsdp_pkg::PH_MAYBE_OFF;
            end
            bsdp_pkg::PH_MAYBE_OFF: begin
                if (r_btn_snap == i_buttons) begin
                    n_btn_ph = bsdp_pkg::PH_ON;
                end else begin
                    // confirmed release: act on the held snapshot
                    n_btn_ph   = bsdp_pkg::PH_IDLE;
                    n_btn_snap = bsdp_pkg::PORT_IDLE;
                    priority if (!r_btn_snap[7]) begin
                        send = 1'b1;
                        code = bsdp_pkg::RELEASE_B7;
                    end else if (!r_btn_snap[6]) begin
                        send = 1'b1;
                        code = bsdp_pkg::RELEASE_B6;
                    end else if (!r_btn_snap[5]) begin
                        send = 1'b1;
                        code = bsdp_pkg::RELEASE_B5;
                    end else if (!r_btn_snap[4]) begin
                        n_move = ~r_move;
                        calib  = ~r_move;
                    end else if (!r_btn_snap[3]) begin
                        n_scroll = ~r_scroll;
                        calib    = ~r_scroll;
                    end else begin
                        // release of unused bits only ends the press
                        calib = 1'b0;
                    end
                end
            end
            default: n_btn_ph = bsdp_pkg::PH_IDLE;
        endcase
    end

    // Switch debounce; snapshot keeps the new value on a failed check
    always_comb begin
        n_sw_ph   = r_sw_ph;
        n_sw_snap = r_sw_snap;
        apply_sw  = 1'b0;
        unique case (r_sw_ph)
            bsdp_pkg::PH_IDLE: begin
                if (i_switches != r_sw_snap) begin
                    n_sw_ph   = bsdp_pkg::PH_MAYBE_ON;
                    n_sw_snap = i_switches;
                end
            end
            bsdp_pkg::PH_MAYBE_ON: begin
                if (i_switches == r_sw_snap) begin
                    n_sw_ph  = bsdp_pkg::PH_ON;
                    apply_sw = 1'b1;
                end else begin
                    n_sw_ph = bsdp_pkg::PH_IDLE;
                end
            end
            bsdp_pkg::PH_ON: begin
                if (i_switches != r_sw_snap) begin
                    n_sw_ph   = bsdp_pkg::PH_MAYBE_OFF;
                    n_sw_snap = i_switches;
                end
            end
            bsdp_pkg::PH_MAYBE_OFF: begin
                if (i_switches == r_sw_snap) begin
                    n_sw_ph  = bsdp_pkg::PH_IDLE;
                    apply_sw = 1'b1;
                end else begin
                    n_sw_ph = bsdp_pkg::PH_ON;
                end
            end
            default: n_sw_ph = bsdp_pkg::PH_IDLE;
        endcase
    end

    // Switch mapping: bit 0 low -> high sensitivity, bits 2/3 high -> inverted
    always_comb begin
        n_sens  = r_sens;
        n_inv_x = r_inv_x;
        n_inv_y = r_inv_y;
        if (apply_sw) begin
            n_sens  = i_switches[0] ? bsdp_pkg::SENS_LOW : bsdp_pkg::SENS_HIGH;
            n_inv_x = i_switches[2];
            n_inv_y = i_switches[3];
        end
    end

    // Command carries status after this sample
    always_comb begin
        o_cmd.send   = send;
        o_cmd.code   = code;
        o_cmd.move   = n_move;
        o_cmd.scroll = n_scroll;
        o_cmd.calib  = calib;
        o_cmd.sens   = n_sens;
        o_cmd.inv_x  = n_inv_x;
        o_cmd.inv_y  = n_inv_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btn_ph   <= bsdp_pkg::PH_IDLE;
            r_sw_ph    <= bsdp_pkg::PH_IDLE;
            r_btn_snap <= bsdp_pkg::PORT_IDLE;
            r_sw_snap  <= bsdp_pkg::PORT_IDLE;
            r_move     <= 1'b0;
            r_scroll   <= 1'b0;
            r_sens     <= '0;
            r_inv_x    <= 1'b0;
            r_inv_y    <= 1'b0;
        end else if (i_accept) begin
            r_btn_ph   <= n_btn_ph;
            r_sw_ph    <= n_sw_ph;
            r_btn_snap <= n_btn_snap;
            r_sw_snap  <= n_sw_snap;
            r_move     <= n_move;
            r_scroll   <= n_scroll;
            r_sens     <= n_sens;
            r_inv_x    <= n_inv_x;
            r_inv_y    <= n_inv_y;
        end
    end

endmodule

`default_nettype wire

### hdl/bsdp_queue.sv
// Small command queue between front and back.
// Depends on bsdp_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module bsdp_queue #(
    parameter int DEPTH = bsdp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire bsdp_pkg::t_cmd i_data,
    output logic          o_full,
    input  wire logic     i_pop,
    output logic          o_empty,
    output bsdp_pkg::t_cmd o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bsdp_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Storage write
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

endmodule

`default_nettype wire

### hdl/bsdp_back.sv
// Back end: turns queued commands into output items via a registered output stage,
// one per cycle unless stalled. Holds the config registers. Depends on bsdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsdp_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_addr,
    input  wire logic [bsdp_pkg::BYTE_W-1:0]   i_cfg_wdata,
    input  wire bsdp_pkg::t_cmd                i_cmd,
    input  wire logic                          i_empty,
    output logic                               o_pop,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [bsdp_pkg::M_DATA_W-1:0]      o_m_tdata,
    output logic                               o_m_tlast,
    output logic                               o_m_tuser
);

    logic [bsdp_pkg::BYTE_W-1:0]   r_sync, r_addr;
    logic [bsdp_pkg::IDX_W-1:0]    r_idx;
    logic                          r_m_tvalid;
    logic [bsdp_pkg::M_DATA_W-1:0] r_m_tdata;
    logic                          r_m_tlast;
    logic                          r_m_tuser;
    logic                          can_load;
    logic                          advance;
    logic                          is_last;
    logic [bsdp_pkg::BYTE_W-1:0]   tx_byte;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= bsdp_pkg::SYNC_RESET;
            r_addr <= bsdp_pkg::ADDR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                bsdp_pkg::CFG_SYNC: r_sync <= i_cfg_wdata;
                bsdp_pkg::CFG_ADDR: r_addr <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Step through the head command; pop on its final item
    assign can_load = !r_m_tvalid || i_m_tready;
    assign advance  = can_load && !i_empty;
    assign is_last  = !i_cmd.send || (r_idx == bsdp_pkg::IDX_CODE);
    assign o_pop    = advance && is_last;

    // Packet byte at the current position
    always_comb begin
        tx_byte = '0;
        if (i_cmd.send) begin
            priority if (r_idx == bsdp_pkg::IDX_SYNC) tx_byte = r_sync;
            else if (r_idx == bsdp_pkg::IDX_ADDR) tx_byte = r_addr;
            else if (r_idx == bsdp_pkg::IDX_CODE) tx_byte = i_cmd.code;
            else tx_byte = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (advance) begin
                r_idx <= is_last ? '0 : r_idx + 1'b1;
            end
            if (can_load) r_m_tvalid <= !i_empty;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_m_tdata <= {i_cmd.inv_y, i_cmd.inv_x, i_cmd.sens, i_cmd.calib,
                          i_cmd.scroll, i_cmd.move, tx_byte};
            r_m_tlast <= is_last;
            r_m_tuser <= i_cmd.send;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tlast  = r_m_tlast;
    assign o_m_tuser  = r_m_tuser;

    a_mid_packet_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> (!i_empty && i_cmd.send))
        else $error("packet position advanced without a held packet command");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= bsdp_pkg::IDX_CODE)
        else $error("packet position out of range");
    a_no_byte_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_tvalid && !r_m_tuser) |-> r_m_tlast)
        else $error("item without packet byte not marked last");

endmodule

`default_nettype wire

### hdl/button_switch_debounce_packetizer.sv
// Top level of the button/switch debounce packetizer: front, queue, back.
// Depends on bsdp_pkg, bsdp_front, bsdp_queue, bsdp_back.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  s       | in        | i_s_tvalid/o_s_tready | tdata[7:0] buttons, [15:8] switches
//  m       | out       | o_m_tvalid/i_m_tready | tdata, tlast = last, tuser = byte_valid
//  cfg     | in        | i_cfg_we            | i_cfg_addr index, i_cfg_wdata value
//
// A sample is accepted every cycle while the command queue has room.
// Each sample yields one output item, or six for a click packet; the back end
// emits one item per cycle while the output is not stalled.
// An accepted sample passes the queue storage and the back end output register.
// Synchronous active-low reset; no clearing pass, a sample can be taken at the
// first edge after reset is released.
// An output stall fills the queue, after which o_s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module button_switch_debounce_packetizer #(
    parameter int QUEUE_DEPTH = bsdp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // config write port
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_addr,
    input  wire logic [bsdp_pkg::BYTE_W-1:0]   i_cfg_wdata,
    // sample stream
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [bsdp_pkg::S_DATA_W-1:0] i_s_tdata,  // [7:0] buttons, [15:8] switches
    // packet stream
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [7:0] tx_byte, [8] move_enable, [9] scroll_enable, [10] calibrate_request,
    // [13:11] sensitivity, [14] invert_x_negative, [15] invert_y_negative
    output logic [bsdp_pkg::M_DATA_W-1:0]      o_m_tdata,
    output logic                               o_m_tlast,
    output logic                               o_m_tuser   // [0] byte_valid
);

    logic           s_accept;
    logic           q_full, q_empty, q_pop;
    bsdp_pkg::t_cmd front_cmd, head_cmd;

    assign o_s_tready = !q_full;
    assign s_accept   = i_s_tvalid && !q_full;

    bsdp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (s_accept),
        .i_buttons  (i_s_tdata[7:0]),
        .i_switches (i_s_tdata[15:8]),
        .o_cmd      (front_cmd)
    );

    bsdp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_accept),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (head_cmd)
    );

    bsdp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (head_cmd),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

`default_nettype wire

### tb/bsdp_click_checker.sv
// Scoreboard for the button/switch debounce packetizer: tracks config writes,
// debounces every accepted sample and compares each output beat. Uses bsdp_pkg.
`timescale 1ns / 1ps

module bsdp_click_checker
    import bsdp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_addr,
    input  logic [BYTE_W-1:0]   i_cfg_wdata,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // [7:0] buttons, [15:8] switches
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    // [7:0] tx_byte, [8] move_enable, [9] scroll_enable, [10] calibrate_request,
    // [13:11] sensitivity, [14] invert_x_negative, [15] invert_y_negative
    input  logic [M_DATA_W-1:0] i_m_tdata,
    input  logic                i_m_tlast,
    input  logic                i_m_tuser,   // [0] byte_valid
    input  logic                i_drain_check,
    output int                  o_pending,
    output int                  o_fail_count
);

    // One expected output beat
    typedef struct packed {
        logic [BYTE_W-1:0] tx_byte;
        logic              byte_valid;
        logic              is_last;
        logic              move_bit;
        logic              scroll_bit;
        logic              calib;
        logic [SENS_W-1:0] sens;
        logic              inv_x;
        logic              inv_y;
    } t_click_beat;

    t_click_beat       expected_beats[$];

    // Shadow of the block's state and registers
    t_phase            btn_phase;
    t_phase            sw_phase;
    logic [BYTE_W-1:0] btn_snap;
    logic [BYTE_W-1:0] sw_snap;
    logic [BYTE_W-1:0] sync_val;
    logic [BYTE_W-1:0] addr_val;
    logic              move_on;
    logic              scroll_on;
    logic [SENS_W-1:0] sens_lvl;
    logic              inv_x_on;
    logic              inv_y_on;
    int                fail_count;
    logic              leftover_reported;

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    task automatic latch_switches(input logic [BYTE_W-1:0] sw);
        sens_lvl = sw[0] ? SENS_LOW : SENS_HIGH;
        inv_x_on = sw[2];
        inv_y_on = sw[3];
    endtask

    // Advance both debouncers by one sample and queue the beats it produces
    task automatic debounce_sample(input logic [BYTE_W-1:0] btn, input logic [BYTE_W-1:0] sw);
        logic              send;
        logic [BYTE_W-1:0] code;
        logic              calib;
        int                n;
        t_click_beat       beat;
        send  = 1'b0;
        code  = '0;
        calib = 1'b0;

        // button machine: press sends on bits 7..5, release also handles 4 and 3
        case (btn_phase)
            PH_IDLE: begin
                if (btn != PORT_IDLE) begin
                    btn_phase = PH_MAYBE_ON;
                    btn_snap  = btn;
                end
            end
            PH_MAYBE_ON: begin
                if (btn == btn_snap) begin
                    btn_phase = PH_ON;
                    send      = 1'b1;
                    if (!btn[7])      code = PRESS_B7;
                    else if (!btn[6]) code = PRESS_B6;
                    else if (!btn[5]) code = PRESS_B5;
                    else              send = 1'b0;
                end else begin
                    btn_phase = PH_IDLE;
                end
            end
            PH_ON: begin
                if (btn != btn_snap) btn_phase = PH_MAYBE_OFF;
            end
            default: begin
                if (btn == btn_snap) begin
                    btn_phase = PH_ON;
                end else begin
                    btn_phase = PH_IDLE;
                    send      = 1'b1;
                    if (!btn_snap[7])      code = RELEASE_B7;
                    else if (!btn_snap[6]) code = RELEASE_B6;
                    else if (!btn_snap[5]) code = RELEASE_B5;
                    else begin
                        send = 1'b0;
                        if (!btn_snap[4]) begin
                            move_on = !move_on;
                            calib   = move_on;
                        end else if (!btn_snap[3]) begin
                            scroll_on = !scroll_on;
                            calib     = scroll_on;
                        end
                    end
                    btn_snap = PORT_IDLE;
                end
            end
        endcase

        // switch machine: a failed debounce keeps the new snapshot
        case (sw_phase)
            PH_IDLE: begin
                if (sw != sw_snap) begin
                    sw_phase = PH_MAYBE_ON;
                    sw_snap  = sw;
                end
            end
            PH_MAYBE_ON: begin
                if (sw == sw_snap) begin
                    sw_phase = PH_ON;
                    latch_switches(sw);
                end else begin
                    sw_phase = PH_IDLE;
                end
            end
            PH_ON: begin
                if (sw != sw_snap) begin
                    sw_phase = PH_MAYBE_OFF;
                    sw_snap  = sw;
                end
            end
            default: begin
                if (sw == sw_snap) begin
                    sw_phase = PH_IDLE;
                    latch_switches(sw);
                end else begin
                    sw_phase = PH_ON;
                end
            end
        endcase

        // one status beat, or a six-byte packet
        n = send ? 6 : 1;
        for (int k = 0; k < n; k++) begin
            beat = '0;
            if (send) begin
                if (k == IDX_SYNC)      beat.tx_byte = sync_val;
                else if (k == IDX_ADDR) beat.tx_byte = addr_val;
                else if (k == IDX_CODE) beat.tx_byte = code;
            end
            beat.byte_valid = send;
            beat.is_last    = (k == n - 1);
            beat.move_bit   = move_on;
            beat.scroll_bit = scroll_on;
            beat.calib      = calib;
            beat.sens       = sens_lvl;
            beat.inv_x      = inv_x_on;
            beat.inv_y      = inv_y_on;
            expected_beats.push_back(beat);
        end
    endtask

    always @(posedge i_clk) begin
        t_click_beat want;
        if (!i_rst_n) begin
            btn_phase         = PH_IDLE;
            sw_phase          = PH_IDLE;
            btn_snap          = PORT_IDLE;
            sw_snap           = PORT_IDLE;
            sync_val          = SYNC_RESET;
            addr_val          = ADDR_RESET;
            move_on           = 1'b0;
            scroll_on         = 1'b0;
            sens_lvl          = '0;
            inv_x_on          = 1'b0;
            inv_y_on          = 1'b0;
            leftover_reported = 1'b0;
            expected_beats.delete();
        end else begin
            // outputs first: a beat accepted now cannot stem from a sample accepted now
            if (i_m_tvalid && i_m_tready) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected output beat: tdata 0x%0h tlast %0b tuser %0b",
                           i_m_tdata, i_m_tlast, i_m_tuser);
                    fail_count++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("tx_byte", int'(want.tx_byte), int'(i_m_tdata[7:0]));
                    check_field("byte_valid", int'(want.byte_valid), int'(i_m_tuser));
                    check_field("last", int'(want.is_last), int'(i_m_tlast));
                    check_field("move_enable", int'(want.move_bit), int'(i_m_tdata[8]));
                    check_field("scroll_enable", int'(want.scroll_bit),
                                int'(i_m_tdata[9]));
                    check_field("calibrate_request", int'(want.calib),
                                int'(i_m_tdata[10]));
                    check_field("sensitivity", int'(want.sens), int'(i_m_tdata[13:11]));
                    check_field("invert_x_negative", int'(want.inv_x),
                                int'(i_m_tdata[14]));
                    check_field("invert_y_negative", int'(want.inv_y),
                                int'(i_m_tdata[15]));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_SYNC)      sync_val = i_cfg_wdata;
                else if (i_cfg_addr == CFG_ADDR) addr_val = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready)
                debounce_sample(i_s_tdata[7:0], i_s_tdata[15:8]);
            if (i_drain_check && !leftover_reported && expected_beats.size() != 0) begin
                $error("%0d expected beats never arrived", expected_beats.size());
                fail_count++;
                leftover_reported = 1'b1;
            end
        end
        o_pending    = expected_beats.size();
        o_fail_count = fail_count;
    end

endmodule

### tb/button_switch_debounce_packetizer_tb.sv
// Testbench top for the button/switch debounce packetizer: clock, reset,
// sample and config stimulus, output back-pressure. Uses bsdp_pkg, bsdp_click_checker.
`timescale 1ns / 1ps

module button_switch_debounce_packetizer_tb;
    import bsdp_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic                cfg_addr;
    logic [BYTE_W-1:0]   cfg_wdata;
    logic                s_tvalid;
    wire                 s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    wire                 m_tvalid;
    logic                m_tready;
    wire [M_DATA_W-1:0]  m_tdata;
    wire                 m_tlast;
    wire                 m_tuser;
    logic                drain_check;
    int                  pending;
    int                  fail_count;
    logic                calm;          // no idle gaps on either side while set
    logic [BYTE_W-1:0]   switch_level;  // switch port value held by the press sequences

    // Directed samples as {switches, buttons}
    logic [S_DATA_W-1:0] directed_seq [30] = '{
        16'hFE7F, 16'hFEBF,                         // press that fails to settle
        16'hFE7F, 16'hFE7F,                         // press bit 7, switches steady
        16'hFEFF, 16'hFE7F, 16'hFEFF, 16'hFEFF,     // release bounce, then release
        16'hF29F, 16'hF29F, 16'hF2FF, 16'hF2FF,     // bits 6 and 5 together
        16'hF3DF, 16'hF3DF,                         // press bit 5
        16'h00EF, 16'hF3EF,                         // release bit 5, switch glitch
        16'hF3EF, 16'hF3EF, 16'hF3F7, 16'hF3F7,     // bit 4 toggles move
        16'hF3F7, 16'hF3F7, 16'hF3FE, 16'hF3FE,     // bit 3 toggles scroll
        16'hF3FE, 16'hF3FE, 16'hF300, 16'hF300,     // release of unused bits only
        16'hF300, 16'hF300                          // everything pressed
    };

    always #5 i_clk = ~i_clk;

    button_switch_debounce_packetizer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .o_m_tuser   (m_tuser)
    );

    bsdp_click_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tlast     (m_tlast),
        .i_m_tuser     (m_tuser),
        .i_drain_check (drain_check),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // Offer one sample request after a random gap (none if calm), hold until accepted
    task automatic push_sample(input logic [BYTE_W-1:0] btn, input logic [BYTE_W-1:0] sw);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tdata  <= {sw, btn};
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [BYTE_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
    endtask

    // Drain the block, then load both packet header registers
    task automatic reconfigure(input logic [BYTE_W-1:0] sync_v, input logic [BYTE_W-1:0] addr_v);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        write_cfg(CFG_SYNC, sync_v);
        write_cfg(CFG_ADDR, addr_v);
        cfg_we <= 1'b0;
    endtask

    // Mostly clean press/release sequences, some raw noise
    task automatic random_phase(input int count);
        int                sent;
        int                hold;
        int                rel;
        logic [BYTE_W-1:0] pat;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 2) == 0) switch_level = BYTE_W'($urandom_range(0, 255));
            if ($urandom_range(0, 9) < 8) begin
                if ($urandom_range(0, 3) == 0) pat = BYTE_W'($urandom_range(0, 254));
                else                           pat = ~(8'h01 << $urandom_range(3, 7));
                hold = $urandom_range(2, 4);
                rel  = $urandom_range(2, 3);
                repeat (hold) begin
                    push_sample(pat, switch_level);
                    sent++;
                end
                repeat (rel) begin
                    push_sample(PORT_IDLE, switch_level);
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    push_sample(BYTE_W'($urandom_range(0, 255)),
                                BYTE_W'($urandom_range(0, 255)));
                    sent++;
                end
            end
        end
    endtask

    // Output side: random stall before each beat, none while calm
    initial begin : output_sink
        int stall;
        m_tready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Hard stop if the run hangs
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int guard;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = CFG_SYNC;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        drain_check  = 1'b0;
        calm         = 1'b0;
        switch_level = PORT_IDLE;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part runs with the reset header bytes
        foreach (directed_seq[i])
            push_sample(directed_seq[i][7:0], directed_seq[i][15:8]);

        reconfigure(8'h00, 8'h00);
        random_phase(50);

        reconfigure(8'hFF, 8'hFF);
        calm = 1'b1;
        random_phase(50);
        calm = 1'b0;

        reconfigure(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
        random_phase(50);

        reconfigure(8'h5A, 8'hA5);
        random_phase(50);

        // drain and settle
        s_tvalid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 5000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (8) @(negedge i_clk);
        drain_check <= 1'b1;
        @(negedge i_clk);
        @(negedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
hdl/bsdp_pkg.sv
hdl/bsdp_front.sv
hdl/bsdp_queue.sv
hdl/bsdp_back.sv
hdl/button_switch_debounce_packetizer.sv
tb/bsdp_click_checker.sv
tb/button_switch_debounce_packetizer_tb.sv
